// File: hw/rtl/definition_name_scanner_defines.svh
// Assertion macros for the definition name scanner.
`ifndef DEFINITION_NAME_SCANNER_DEFINES_SVH
`define DEFINITION_NAME_SCANNER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DNS_ASSERT_SAME(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DNS_ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/dns_pkg.sv
package dns_pkg;

  localparam logic OP_TEXT = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CHR_NL   = 8'd10;
  localparam logic [7:0] CHR_HASH = 8'd35;
  localparam logic [7:0] CHR_EQ   = 8'd61;
  localparam logic [7:0] CHR_US   = 8'd95;

  typedef enum logic [1:0] {
    CLS_SPACE,
    CLS_WORD,
    CLS_PUNCT
  } dns_class_e;

  typedef struct packed {
    logic       op;
    logic [7:0] in_byte;
  } dns_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } dns_out_t;

  typedef struct packed {
    logic step;
    logic rd;
    logic push_byte;
    logic push_nl;
  } dns_cmd_t;

  typedef struct packed {
    logic emit;
    logic at_end;
    logic out_free;
  } dns_sts_t;

  function automatic dns_class_e dns_classify(input logic [7:0] b);
    dns_class_e c;
    c = CLS_SPACE;
    if ((b >= 8'd48 && b <= 8'd57) || (b >= 8'd65 && b <= 8'd90) ||
        (b >= 8'd97 && b <= 8'd122) || b == CHR_US) begin
      c = CLS_WORD;
    end else if (b >= 8'd33 && b <= 8'd126) begin
      c = CLS_PUNCT;
    end
    return c;
  endfunction

  function automatic logic [7:0] dns_def_char(input logic [1:0] i);
    logic [7:0] c;
    unique case (i)
      2'd0:    c = 8'd100;
      2'd1:    c = 8'd101;
      2'd2:    c = 8'd102;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] dns_class_char(input logic [2:0] i);
    logic [7:0] c;
    unique case (i)
      3'd0:    c = 8'd99;
      3'd1:    c = 8'd108;
      3'd2:    c = 8'd97;
      3'd3:    c = 8'd115;
      3'd4:    c = 8'd115;
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

// File: hw/rtl/dns_ctrl.sv
module dns_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dns_pkg::dns_sts_t sts_i,
  output dns_pkg::dns_cmd_t cmd_o
);
  import dns_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.step = in_valid_i;
        if (in_valid_i && sts_i.emit) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (!sts_i.at_end) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_LOAD;
        end else if (sts_i.out_free) begin
          cmd_o.push_nl = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.push_byte = 1'b1;
          state_d         = ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// File: hw/rtl/dns_datapath.sv
module dns_datapath #(
  parameter int unsigned WORD_STORE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dns_pkg::dns_in_t  in_data_i,
  input  logic              out_ready_i,
  input  dns_pkg::dns_cmd_t cmd_i,
  output dns_pkg::dns_sts_t sts_o,
  output logic              out_valid_o,
  output dns_pkg::dns_out_t out_data_o
);
  import dns_pkg::*;

  localparam int unsigned IDX_W     = $clog2(WORD_STORE - 1);
  localparam int unsigned LEN_W     = $clog2(WORD_STORE);
  localparam int unsigned XW        = (LEN_W > 3) ? LEN_W : 3;
  localparam int unsigned MEM_DEPTH = 2 ** (IDX_W + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(WORD_STORE - 1);

  logic [LEN_W-1:0] cur_len_q, prev_len_q, emit_len_q, idx_q;
  logic             cur_col0_q, cur_def_q, cur_cls_q, cur_eq_q;
  logic             prev_col0_q, prev_kw_q;
  dns_class_e       last_cls_q;
  logic             line_start_q, in_comment_q, bank_q, emit_bank_q;
  logic             pend_q;
  logic [IDX_W:0]   pend_addr_q;
  logic [7:0]       pend_byte_q;
  logic             out_valid_q, out_last_q;
  logic [7:0]       out_byte_q, rd_data_q;
  logic [7:0]       mem [MEM_DEPTH];

  logic [7:0]       b;
  logic             is_end;
  dns_class_e       cls, last_cls_d;
  logic             do_close, do_append, comment_d, line_start_d;
  logic             close1, close2, closing, eff_bank;
  logic [LEN_W-1:0] eff_len, app_len, tok_len;
  logic [XW-1:0]    eff_x, tok_x;
  logic             app_def, app_cls, app_eq, app_col0;
  logic             tok_def, tok_cls, tok_eq, tok_col0;
  logic             emit_cur, emit_prev, defer, we;
  logic [IDX_W:0]   wr_addr, we_addr;
  logic [7:0]       we_byte;

  always_comb begin
    b            = in_data_i.in_byte;
    is_end       = (in_data_i.op == OP_END);
    cls          = dns_classify(b);
    do_close     = 1'b0;
    do_append    = 1'b0;
    comment_d    = in_comment_q;
    last_cls_d   = last_cls_q;
    line_start_d = line_start_q;
    priority if (is_end) begin
      do_close = 1'b1;
    end else if (in_comment_q && b != CHR_NL) begin
      comment_d = 1'b1;
    end else if (!in_comment_q && b == CHR_HASH) begin
      do_close  = 1'b1;
      comment_d = 1'b1;
    end else begin
      comment_d = 1'b0;
      if (cls != last_cls_q) begin
        do_close   = (last_cls_q != CLS_SPACE);
        do_append  = (cls != CLS_SPACE);
        last_cls_d = cls;
      end else begin
        do_append = (cls != CLS_SPACE);
      end
      line_start_d = (b == CHR_NL);
    end

    close1   = do_close && (cur_len_q != '0);
    eff_len  = close1 ? '0 : cur_len_q;
    eff_bank = close1 ? ~bank_q : bank_q;
    eff_x    = XW'(eff_len);
    app_def  = ((eff_len == '0) || cur_def_q) && (eff_x < XW'(3)) &&
               (b == dns_def_char(eff_x[1:0]));
    app_cls  = ((eff_len == '0) || cur_cls_q) && (eff_x < XW'(5)) &&
               (b == dns_class_char(eff_x[2:0]));
    app_eq   = (eff_len == '0) ? (b == CHR_EQ) : cur_eq_q;
    app_col0 = (eff_len == '0) ? line_start_q : cur_col0_q;
    app_len  = eff_len + LEN_W'(1);
    close2   = do_append && (app_len == MAX_LEN);
    closing  = close1 || close2;

    tok_len  = close1 ? cur_len_q  : app_len;
    tok_def  = close1 ? cur_def_q  : app_def;
    tok_cls  = close1 ? cur_cls_q  : app_cls;
    tok_eq   = close1 ? cur_eq_q   : app_eq;
    tok_col0 = close1 ? cur_col0_q : app_col0;
    tok_x    = XW'(tok_len);

    emit_cur  = closing && prev_kw_q;
    emit_prev = closing && !prev_kw_q && prev_col0_q && (tok_x == XW'(1)) && tok_eq;
    defer     = emit_prev && do_append && close1;
    wr_addr   = {eff_bank, eff_len[IDX_W-1:0]};

    we      = (cmd_i.step && do_append && !defer) || (cmd_i.push_nl && pend_q);
    we_addr = pend_q ? pend_addr_q : wr_addr;
    we_byte = pend_q ? pend_byte_q : b;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[we_addr] <= we_byte;
    end
    if (cmd_i.rd) begin
      rd_data_q <= mem[{emit_bank_q, idx_q[IDX_W-1:0]}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_byte) begin
      out_byte_q <= rd_data_q;
    end else if (cmd_i.push_nl) begin
      out_byte_q <= CHR_NL;
    end
    if (cmd_i.step && do_append && defer) begin
      pend_addr_q <= wr_addr;
      pend_byte_q <= b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_len_q    <= '0;
      cur_col0_q   <= 1'b0;
      cur_def_q    <= 1'b0;
      cur_cls_q    <= 1'b0;
      cur_eq_q     <= 1'b0;
      prev_len_q   <= '0;
      prev_col0_q  <= 1'b1;
      prev_kw_q    <= 1'b0;
      last_cls_q   <= CLS_SPACE;
      line_start_q <= 1'b1;
      in_comment_q <= 1'b0;
      bank_q       <= 1'b0;
      emit_bank_q  <= 1'b0;
      emit_len_q   <= '0;
      idx_q        <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_last_q   <= 1'b0;
    end else begin
      if (cmd_i.step) begin
        if (closing) begin
          prev_len_q  <= tok_len;
          prev_col0_q <= tok_col0;
          prev_kw_q   <= ((tok_x == XW'(3)) && tok_def) || ((tok_x == XW'(5)) && tok_cls);
          bank_q      <= ~bank_q;
        end
        if (close2) begin
          cur_len_q <= '0;
        end else if (do_append) begin
          cur_len_q <= app_len;
        end else begin
          cur_len_q <= eff_len;
        end
        if (do_append) begin
          cur_def_q  <= app_def;
          cur_cls_q  <= app_cls;
          cur_eq_q   <= app_eq;
          cur_col0_q <= app_col0;
        end
        last_cls_q   <= last_cls_d;
        line_start_q <= line_start_d;
        in_comment_q <= comment_d;
        emit_bank_q  <= emit_cur ? bank_q : ~bank_q;
        emit_len_q   <= emit_cur ? tok_len : prev_len_q;
        idx_q        <= '0;
        if (do_append && defer) begin
          pend_q <= 1'b1;
        end
        if (is_end) begin
          cur_len_q    <= '0;
          cur_col0_q   <= 1'b0;
          prev_len_q   <= '0;
          prev_col0_q  <= 1'b1;
          prev_kw_q    <= 1'b0;
          last_cls_q   <= CLS_SPACE;
          line_start_q <= 1'b1;
          in_comment_q <= 1'b0;
        end
      end
      if (cmd_i.rd) begin
        idx_q <= idx_q + LEN_W'(1);
      end
      if (cmd_i.push_nl) begin
        pend_q <= 1'b0;
      end
      if (cmd_i.push_byte || cmd_i.push_nl) begin
        out_valid_q <= 1'b1;
        out_last_q  <= cmd_i.push_nl;
      end else if (sts_o.out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.emit     = emit_cur || emit_prev;
  assign sts_o.at_end   = (idx_q == emit_len_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o         = out_valid_q;
  assign out_data_o.out_byte = out_byte_q;
  assign out_data_o.last     = out_last_q;

endmodule

// File: hw/rtl/definition_name_scanner.sv
// Definition name scanner. Takes source text one item per byte (op 0) and an
// end-of-stream item (op 1) that closes any open token and returns the block to
// its reset state. For every name that follows def or class, and for every
// column-zero token followed by a lone '=', it sends the name one byte per
// output item, then a newline item with last set. A byte that emits nothing
// leaves the block ready for the next byte in the following cycle. A byte that
// emits a name keeps the input side busy while it is sent, longer while the
// output stalls: each name byte needs a registered read of the two-bank token
// store and then a load into the output register, and the newline is loaded
// from the read state. The output register lets the next byte be taken while
// the final newline still waits. The token store needs no clearing after reset.
`include "definition_name_scanner_defines.svh"

module definition_name_scanner #(
  parameter int unsigned WORD_STORE = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dns_pkg::dns_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output dns_pkg::dns_out_t out_data_o
);
  import dns_pkg::*;

  dns_cmd_t cmd;
  dns_sts_t sts;

  dns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dns_datapath #(
    .WORD_STORE (WORD_STORE)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

  `DNS_ASSERT_SAME(a_push_needs_room, clk_i, rst_ni, cmd.push_byte || cmd.push_nl, sts.out_free, "output register overwritten")
  `DNS_ASSERT_SAME(a_no_accept_in_read, clk_i, rst_ni, cmd.rd, !in_ready_o, "item accepted during name read")
  `DNS_ASSERT_NEXT(a_idle_after_nl, clk_i, rst_ni, cmd.push_nl, in_ready_o, "no return to idle after newline")
  `DNS_ASSERT_NEXT(a_quiet_item_idle, clk_i, rst_ni, in_valid_i && in_ready_o && !sts.emit, in_ready_o, "item without name left block busy")

endmodule
